// ===== hw/rtl/pidaw_pkg.sv =====
// ============================================================================
// pidaw_pkg
// Types and constants shared by the anti-windup PID controller and its parts.
// ============================================================================
package pidaw_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [2:0] REG_RATE       = 3'd3;
   localparam logic [2:0] REG_DRIVE_LIM  = 3'd4;
   localparam logic [2:0] REG_INTEG_LIM  = 3'd5;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int SUM_WIDTH      = 25;
   localparam int DRIVE_WIDTH    = 16;

   // Every product magnitude saturates at 2^MAG_WIDTH.
   localparam int MAG_WIDTH = 61;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_P,
      OP_MUL_D1,
      OP_MUL_D2,
      OP_MUL_I,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_TEST,
      OP_INTEG,
      OP_FINISH,
      OP_REPEAT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_P,
      ST_MUL_D1,
      ST_MUL_D2,
      ST_MUL_I,
      ST_DIV_START,
      ST_DIV_STEP,
      ST_TEST,
      ST_INTEG,
      ST_FINISH,
      ST_REPEAT,
      ST_OUT
   } state_type;

   // Status reported by the datapath to the controller.
   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic in_window;
      logic second_pass;
   } dp_status_type;

endpackage

// ===== hw/rtl/pid_conditional_antiwindup.sv =====
// ============================================================================
// pid_conditional_antiwindup
// PID controller with conditional-integration anti-windup.
// ============================================================================
//   channel  ports                      transfer when
//   req      req_valid/ready, error     req_valid && req_ready
//   rsp      rsp_valid/ready, drive,    rsp_valid && rsp_ready
//            status
//   csr      csr_we, csr_index, data    csr_we
//
// A bit-serial multiplier (one multiplier bit per cycle) runs four products
// (P, D1, D2 and I), then a restoring divider runs, and the result is
// offered. When the sample is integrated the integral term is recomputed. A
// zero sample rate skips the multiplies and the divide. Reset clears the
// integral and last error. A result held by rsp_ready stalls the next input,
// which is taken no earlier than the cycle after the result transfer.
module pid_conditional_antiwindup #(
   parameter int ERROR_WIDTH    = 16,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [ERROR_WIDTH-1:0] req_error,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [15:0]            rsp_drive,
   output logic                          rsp_status,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [pidaw_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   logic signed [31:0] kp_ff, ki_ff, kd_ff;
   logic [15:0] rate_ff;
   logic [14:0] dlim_ff;
   logic [23:0] ilim_ff;
   logic status_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         rate_ff <= '0;
         dlim_ff <= 15'h7fff;
         ilim_ff <= 24'hffffff;
      end else if (csr_we) begin
         unique case (csr_index)
            pidaw_pkg::REG_PROP_GAIN:  kp_ff   <= csr_data;
            pidaw_pkg::REG_INTEG_GAIN: ki_ff   <= csr_data;
            pidaw_pkg::REG_DERIV_GAIN: kd_ff   <= csr_data;
            pidaw_pkg::REG_RATE:       rate_ff <= csr_data[15:0];
            pidaw_pkg::REG_DRIVE_LIM:  dlim_ff <= csr_data[14:0];
            pidaw_pkg::REG_INTEG_LIM:  ilim_ff <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   pidaw_pkg::op_type op;
   pidaw_pkg::dp_status_type dp_status;

   pidaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rate_zero (rate_ff == '0),
      .status    (dp_status),
      .op        (op)
   );

   pidaw_dp #(
      .ERROR_WIDTH    (ERROR_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .op             (op),
      .error_in       (req_error),
      .prop_gain      (kp_ff),
      .integ_gain     (ki_ff),
      .deriv_gain     (kd_ff),
      .sample_rate    (rate_ff),
      .drive_limit    (dlim_ff),
      .integral_limit (ilim_ff),
      .reset          (reset),
      .status         (dp_status),
      .drive          (rsp_drive)
   );

   // Status flag of the tick in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         status_ff <= (rate_ff == '0);
      end
   end
   assign rsp_status = status_ff;

endmodule

// ===== hw/rtl/pidaw_ctrl.sv =====
// ============================================================================
// pidaw_ctrl
// Sequencer for one control tick: multiplies, divide, window test, output.
// ============================================================================
module pidaw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rate_zero,
   input  pidaw_pkg::dp_status_type status,
   output pidaw_pkg::op_type       op
);

   pidaw_pkg::state_type state_ff, state_in;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pidaw_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rate_zero ? pidaw_pkg::ST_REPEAT : pidaw_pkg::ST_LOAD;
            end
         end
         pidaw_pkg::ST_LOAD:   state_in = pidaw_pkg::ST_MUL_P;
         pidaw_pkg::ST_MUL_P: begin
            if (status.mul_done) state_in = pidaw_pkg::ST_MUL_D1;
         end
         pidaw_pkg::ST_MUL_D1: begin
            if (status.mul_done) state_in = pidaw_pkg::ST_MUL_D2;
         end
         pidaw_pkg::ST_MUL_D2: begin
            if (status.mul_done) state_in = pidaw_pkg::ST_MUL_I;
         end
         pidaw_pkg::ST_MUL_I: begin
            if (status.mul_done) state_in = pidaw_pkg::ST_DIV_START;
         end
         pidaw_pkg::ST_DIV_START: state_in = pidaw_pkg::ST_DIV_STEP;
         pidaw_pkg::ST_DIV_STEP: begin
            if (status.div_done) state_in = pidaw_pkg::ST_TEST;
         end
         pidaw_pkg::ST_TEST: begin
            if (status.in_window && !status.second_pass) begin
               state_in = pidaw_pkg::ST_INTEG;
            end else begin
               state_in = pidaw_pkg::ST_FINISH;
            end
         end
         pidaw_pkg::ST_INTEG:  state_in = pidaw_pkg::ST_MUL_I;
         pidaw_pkg::ST_FINISH: state_in = pidaw_pkg::ST_OUT;
         pidaw_pkg::ST_REPEAT: state_in = pidaw_pkg::ST_OUT;
         pidaw_pkg::ST_OUT: begin
            if (rsp_ready) state_in = pidaw_pkg::ST_IDLE;
         end
         default: state_in = pidaw_pkg::ST_IDLE;
      endcase
   end

   // Output decode.
   always_comb begin
      op        = pidaw_pkg::OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         pidaw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !rate_zero) op = pidaw_pkg::OP_LOAD;
         end
         pidaw_pkg::ST_LOAD:      op = pidaw_pkg::OP_NONE;
         pidaw_pkg::ST_MUL_P:     op = pidaw_pkg::OP_MUL_P;
         pidaw_pkg::ST_MUL_D1:    op = pidaw_pkg::OP_MUL_D1;
         pidaw_pkg::ST_MUL_D2:    op = pidaw_pkg::OP_MUL_D2;
         pidaw_pkg::ST_MUL_I:     op = pidaw_pkg::OP_MUL_I;
         pidaw_pkg::ST_DIV_START: op = pidaw_pkg::OP_DIV_START;
         pidaw_pkg::ST_DIV_STEP:  op = pidaw_pkg::OP_DIV_STEP;
         pidaw_pkg::ST_TEST:      op = pidaw_pkg::OP_TEST;
         pidaw_pkg::ST_INTEG:     op = pidaw_pkg::OP_INTEG;
         pidaw_pkg::ST_FINISH:    op = pidaw_pkg::OP_FINISH;
         pidaw_pkg::ST_REPEAT:    op = pidaw_pkg::OP_REPEAT;
         pidaw_pkg::ST_OUT:       rsp_valid = 1'b1;
         default:                 op = pidaw_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidaw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The state entered on an input transfer never offers a result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pidaw_pkg::ST_IDLE && req_valid) |=> !rsp_valid)
      else $error("result offered in the cycle after an input transfer");

   // A held result stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // No input is taken while a tick is being processed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != pidaw_pkg::ST_IDLE) |-> !req_ready)
      else $error("input ready while busy");

endmodule

// ===== hw/rtl/pidaw_dp.sv =====
// ============================================================================
// pidaw_dp
// Datapath: shared shift-add multiplier, radix-2 divider, sums, clamps.
// ============================================================================
module pidaw_dp #(
   parameter int ERROR_WIDTH    = 16,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  pidaw_pkg::op_type                  op,
   input  logic signed [ERROR_WIDTH-1:0]      error_in,
   input  logic signed [31:0]                 prop_gain,
   input  logic signed [31:0]                 integ_gain,
   input  logic signed [31:0]                 deriv_gain,
   input  logic [15:0]                        sample_rate,
   input  logic [14:0]                        drive_limit,
   input  logic [23:0]                        integral_limit,
   input  logic                               reset,
   output pidaw_pkg::dp_status_type           status,
   output logic signed [pidaw_pkg::DRIVE_WIDTH-1:0] drive
);

   localparam int MW   = pidaw_pkg::MAG_WIDTH;
   localparam int SW   = pidaw_pkg::SUM_WIDTH;
   localparam int DRW  = pidaw_pkg::DRIVE_WIDTH;
   localparam int DW   = ERROR_WIDTH + 1;        // width of e - prev magnitude
   localparam int MPW  = (DW > SW) ? DW : SW;    // multiplier register width
   localparam int DENW = 16 + GAIN_FRAC_BITS;
   localparam int CNTW = 7;
   localparam logic [MW:0] CAP = {1'b1, {MW{1'b0}}};  // 2^61 in MW+1 bits
   localparam int TW   = 64;                     // width of signed terms

   // Architectural state.
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [15:0] prev_err_ff;
   logic signed [DRW-1:0] prev_drive_ff;

   // Working registers.
   logic signed [ERROR_WIDTH-1:0] e_ff;
   logic [MW:0] acc_ff;        // saturating product magnitude
   logic [MW:0] mcand_ff;      // multiplicand
   logic [MPW-1:0] mplier_ff;  // multiplier, consumed MSB first, one bit per cycle
   logic [CNTW-1:0] cnt_ff;
   logic signed [TW-1:0] p_ff, d_ff, i_ff;
   logic [MW:0] rem_ff;
   logic [MW:0] quo_ff;
   logic pass_ff;
   logic mul_busy_ff;

   // Magnitudes and signs.
   logic [ERROR_WIDTH:0] e_ext;
   logic signed [ERROR_WIDTH:0] diff;
   logic [31:0] mag_kp, mag_kd, mag_ki;
   logic [ERROR_WIDTH:0] mag_e, mag_diff;
   logic [SW-1:0] mag_sum;
   assign diff    = (ERROR_WIDTH+1)'(e_ff) - (ERROR_WIDTH+1)'(prev_err_ff);
   assign e_ext   = (ERROR_WIDTH+1)'(e_ff);
   assign mag_kp  = prop_gain[31]  ? 32'(-prop_gain)  : 32'(prop_gain);
   assign mag_kd  = deriv_gain[31] ? 32'(-deriv_gain) : 32'(deriv_gain);
   assign mag_ki  = integ_gain[31] ? 32'(-integ_gain) : 32'(integ_gain);
   assign mag_e   = e_ext[ERROR_WIDTH] ? (ERROR_WIDTH+1)'(-e_ext) : e_ext;
   assign mag_diff = diff[ERROR_WIDTH] ? (ERROR_WIDTH+1)'(-diff) : (ERROR_WIDTH+1)'(diff);
   assign mag_sum = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);

   // Multiplier operands, left aligned so that the top bit is consumed first.
   logic [MPW-1:0] mpl_e, mpl_diff, mpl_rate, mpl_sum;
   assign mpl_e    = MPW'(mag_e) << (MPW - DW);
   assign mpl_diff = MPW'(mag_diff) << (MPW - DW);
   assign mpl_rate = MPW'(sample_rate) << (MPW - 16);
   assign mpl_sum  = MPW'(mag_sum) << (MPW - SW);

   // One shift-add step of the multiplier, with saturation at the cap.
   logic [MW+1:0] mac_sum;
   logic [MW:0] mac_next;
   assign mac_sum  = {acc_ff, 1'b0} + (mplier_ff[MPW-1] ? (MW+2)'(mcand_ff) : '0);
   assign mac_next = (acc_ff >= CAP || mac_sum >= (MW+2)'(CAP)) ? CAP : mac_sum[MW:0];

   // Divider: restoring, one quotient bit per cycle.
   logic [DENW-1:0] den;
   logic [MW+1:0] trial;
   assign den   = {sample_rate, {GAIN_FRAC_BITS{1'b0}}};
   assign trial = {rem_ff, quo_ff[MW]};

   // Window test and clamp.
   logic signed [TW-1:0] total;
   logic signed [TW-1:0] lim;
   assign total = p_ff + i_ff + d_ff;
   assign lim   = TW'(drive_limit);

   logic signed [TW-1:0] sum_wide;
   logic signed [TW-1:0] ilim;
   assign sum_wide = TW'(sum_ff) + TW'(e_ff);
   assign ilim     = TW'(integral_limit);

   always_comb begin
      if (sum_wide > ilim)       sum_in = SW'(ilim);
      else if (sum_wide < -ilim) sum_in = SW'(-ilim);
      else                       sum_in = SW'(sum_wide);
   end

   logic signed [TW-1:0] sat_total;
   always_comb begin
      if (total > lim)       sat_total = lim;
      else if (total < -lim) sat_total = -lim;
      else                   sat_total = total;
   end

   // Signed term from magnitude.
   logic signed [TW-1:0] term_mag;
   assign term_mag = TW'(acc_ff >> GAIN_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         prev_err_ff   <= '0;
         prev_drive_ff <= '0;
         mul_busy_ff   <= 1'b0;
      end else begin
         case (op)
            pidaw_pkg::OP_LOAD: begin
               e_ff    <= error_in;
               pass_ff <= 1'b0;
            end
            pidaw_pkg::OP_MUL_P, pidaw_pkg::OP_MUL_D1,
            pidaw_pkg::OP_MUL_D2, pidaw_pkg::OP_MUL_I: begin
               if (!mul_busy_ff) begin
                  // Load operands; the second D multiply scales the first product.
                  mul_busy_ff <= 1'b1;
                  acc_ff      <= '0;
                  case (op)
                     pidaw_pkg::OP_MUL_P: begin
                        mcand_ff  <= (MW+1)'(mag_kp);
                        mplier_ff <= mpl_e;
                        cnt_ff    <= CNTW'(DW);
                     end
                     pidaw_pkg::OP_MUL_D1: begin
                        mcand_ff  <= (MW+1)'(mag_kd);
                        mplier_ff <= mpl_diff;
                        cnt_ff    <= CNTW'(DW);
                     end
                     pidaw_pkg::OP_MUL_D2: begin
                        mcand_ff  <= acc_ff;
                        mplier_ff <= mpl_rate;
                        cnt_ff    <= CNTW'(16);
                     end
                     default: begin
                        mcand_ff  <= (MW+1)'(mag_ki);
                        mplier_ff <= mpl_sum;
                        cnt_ff    <= CNTW'(SW);
                     end
                  endcase
               end else if (cnt_ff != '0) begin
                  acc_ff    <= mac_next;
                  mplier_ff <= {mplier_ff[MPW-2:0], 1'b0};
                  cnt_ff    <= cnt_ff - 1'b1;
               end else begin
                  mul_busy_ff <= 1'b0;
                  case (op)
                     pidaw_pkg::OP_MUL_P:
                        p_ff <= (prop_gain[31] != e_ff[ERROR_WIDTH-1]) ? -term_mag : term_mag;
                     pidaw_pkg::OP_MUL_D2:
                        d_ff <= (deriv_gain[31] != diff[ERROR_WIDTH]) ? -term_mag : term_mag;
                     default: ;
                  endcase
               end
            end
            pidaw_pkg::OP_DIV_START: begin
               rem_ff <= '0;
               quo_ff <= acc_ff;
               cnt_ff <= CNTW'(MW + 1);
            end
            pidaw_pkg::OP_DIV_STEP: begin
               if (cnt_ff != '0) begin
                  if (trial >= (MW+2)'(den)) begin
                     rem_ff <= (MW+1)'(trial - (MW+2)'(den));
                     quo_ff <= {quo_ff[MW-1:0], 1'b1};
                  end else begin
                     rem_ff <= trial[MW:0];
                     quo_ff <= {quo_ff[MW-1:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 1'b1;
               end else begin
                  i_ff <= (integ_gain[31] != sum_ff[SW-1]) ?
                          -TW'(quo_ff) : TW'(quo_ff);
               end
            end
            pidaw_pkg::OP_INTEG: begin
               sum_ff  <= sum_in;
               pass_ff <= 1'b1;
            end
            pidaw_pkg::OP_FINISH: begin
               prev_err_ff   <= 16'(e_ff);
               prev_drive_ff <= DRW'(sat_total);
            end
            default: ;
         endcase
      end
   end

   assign status.mul_done    = mul_busy_ff && cnt_ff == '0;
   assign status.div_done    = cnt_ff == '0 && op == pidaw_pkg::OP_DIV_STEP;
   assign status.in_window   = total < lim && total > -lim;
   assign status.second_pass = pass_ff;
   assign drive              = prev_drive_ff;

   // The accumulated sum never leaves the integral window once written.
   assert property (@(posedge clock) disable iff (reset)
      $past(op) == pidaw_pkg::OP_INTEG |->
         (TW'(sum_ff) <= ilim && TW'(sum_ff) >= -ilim))
      else $error("error sum outside its limit");

   // The stored drive stays inside the drive limit after a tick.
   assert property (@(posedge clock) disable iff (reset)
      $past(op) == pidaw_pkg::OP_FINISH |->
         (TW'(prev_drive_ff) <= lim && TW'(prev_drive_ff) >= -lim))
      else $error("drive outside its limit");

   // Integration happens at most once per tick.
   assert property (@(posedge clock) disable iff (reset)
      (op == pidaw_pkg::OP_INTEG) |-> !pass_ff)
      else $error("second integration in one tick");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking testbench for the anti-windup PID controller. A scoreboard
// tracks the controller state, predicts drive and status for every error
// sample it accepts, and compares each result transfer in order. Runs a
// directed pass and then random configurations, with random idle cycles on
// both channels.
// ============================================================================
module tb;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_RATE_ZERO = 1'b1;
   localparam int   FRAC_BITS        = 16;
   localparam int   STALL_LIMIT      = 20000;
   localparam int   NUM_ITEMS        = 1200;
   localparam longint unsigned MAG_CAP = 64'd1 << 61;

   // Tracks the controller state and holds the expected results in order.
   class pid_scoreboard;
      longint          prop_gain, integ_gain, deriv_gain;
      longint unsigned sample_rate;
      longint          drive_limit, integral_limit;
      longint          error_sum, prev_error, prev_drive;
      logic signed [15:0] drive_q[$];
      logic               status_q[$];
      int                 errors;

      function new();
         prop_gain = 0; integ_gain = 0; deriv_gain = 0; sample_rate = 0;
         drive_limit = 32767; integral_limit = 16777215;
         error_sum = 0; prev_error = 0; prev_drive = 0;
         errors = 0;
      endfunction

      function void configure(logic [2:0] index, logic [31:0] data);
         case (index)
            pidaw_pkg::REG_PROP_GAIN:  prop_gain = longint'($signed(data));
            pidaw_pkg::REG_INTEG_GAIN: integ_gain = longint'($signed(data));
            pidaw_pkg::REG_DERIV_GAIN: deriv_gain = longint'($signed(data));
            pidaw_pkg::REG_RATE:       sample_rate = longint'(data[15:0]);
            pidaw_pkg::REG_DRIVE_LIM:  drive_limit = longint'(data[14:0]);
            pidaw_pkg::REG_INTEG_LIM:  integral_limit = longint'(data[23:0]);
            default: ;
         endcase
      endfunction

      function longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : longint'(v);
      endfunction

      // Product of two magnitudes, saturating at the cap.
      function longint unsigned capped_mul(longint unsigned a, longint unsigned b);
         longint unsigned r;
         if (a == 0 || b == 0) return 0;
         if (a > MAG_CAP / b) return MAG_CAP;
         r = a * b;
         return (r > MAG_CAP) ? MAG_CAP : r;
      endfunction

      function longint apply_sign(longint unsigned m, bit neg);
         return neg ? -longint'(m) : longint'(m);
      endfunction

      function longint integral_term();
         longint unsigned num, den;
         num = capped_mul(magnitude(integ_gain), magnitude(error_sum));
         den = sample_rate << FRAC_BITS;
         return apply_sign(num / den, (integ_gain < 0) != (error_sum < 0));
      endfunction

      // Notes an accepted error sample and queues the result it causes.
      function void note_sample(logic signed [15:0] sample);
         longint e, diff, p, d, i, total;
         longint unsigned dm;
         if (sample_rate == 0) begin
            drive_q.push_back(prev_drive[15:0]);
            status_q.push_back(STATUS_RATE_ZERO);
            return;
         end
         e = longint'(sample);
         diff = e - prev_error;
         p = apply_sign(capped_mul(magnitude(prop_gain), magnitude(e)) >> FRAC_BITS,
                        (prop_gain < 0) != (e < 0));
         dm = capped_mul(capped_mul(magnitude(deriv_gain), magnitude(diff)), sample_rate);
         d = apply_sign(dm >> FRAC_BITS, (deriv_gain < 0) != (diff < 0));
         i = integral_term();
         total = p + i + d;
         // Integrate only while the unclamped drive is inside the window.
         if (total < drive_limit && total > -drive_limit) begin
            error_sum += e;
            if (error_sum > integral_limit) error_sum = integral_limit;
            if (error_sum < -integral_limit) error_sum = -integral_limit;
            i = integral_term();
            total = p + i + d;
         end
         if (total > drive_limit) total = drive_limit;
         if (total < -drive_limit) total = -drive_limit;
         prev_error = e;
         prev_drive = total;
         drive_q.push_back(total[15:0]);
         status_q.push_back(STATUS_OK);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      // Compares one result transfer with the oldest expectation.
      task check_result(logic signed [15:0] drive, logic status);
         if (drive_q.size() == 0) begin
            report($sformatf("unexpected result drive=%0d status=%0b", drive, status));
            return;
         end
         if (drive !== drive_q[0])
            report($sformatf("drive %0d, expected %0d", drive, drive_q[0]));
         if (status !== status_q[0])
            report($sformatf("status %0b, expected %0b", status, status_q[0]));
         void'(drive_q.pop_front());
         void'(status_q.pop_front());
      endtask

      function int pending();
         return drive_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_error;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_drive;
   logic               rsp_status;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   pid_scoreboard sb = new();
   int  samples_taken = 0;
   int  samples_sent = 0;
   int  quiet_cycles = 0;
   bit  idling = 1;

   pid_conditional_antiwindup i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_error  (req_error),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_drive  (rsp_drive),
      .rsp_status (rsp_status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Record transfers on both channels and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_sample(req_error);
            samples_taken++;
         end
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_drive, rsp_status);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // The receiver stalls at random while idling is enabled.
   always @(negedge clock) begin
      rsp_ready <= !(idling && $urandom_range(99) < 29);
   end

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      sb.configure(index, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                            logic [31:0] rate, logic [31:0] dlim, logic [31:0] ilim);
      write_reg(pidaw_pkg::REG_PROP_GAIN, kp);
      write_reg(pidaw_pkg::REG_INTEG_GAIN, ki);
      write_reg(pidaw_pkg::REG_DERIV_GAIN, kd);
      write_reg(pidaw_pkg::REG_RATE, rate);
      write_reg(pidaw_pkg::REG_DRIVE_LIM, dlim);
      write_reg(pidaw_pkg::REG_INTEG_LIM, ilim);
   endtask

   // Sends one sample; called at a falling edge and returns at one.
   task automatic send_sample(logic signed [15:0] sample);
      int target;
      while (idling && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      target = samples_taken + 1;
      req_valid <= 1'b1;
      req_error <= sample;
      do @(negedge clock); while (samples_taken < target);
      samples_sent++;
   endtask

   // Holds the sender until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'd0;
         3: return $urandom;
         default: return $urandom_range(0, 4 * 65536) - 2 * 65536;
      endcase
   endfunction

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd65535;
         3: return $urandom_range(65535);
         default: return $urandom_range(1, 2000);
      endcase
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 400) - 200);
      endcase
   endfunction

   initial begin
      int phase;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_error = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero sample rate straight out of reset repeats the last drive.
      send_sample(16'sd0);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      drain();

      // Unity gains at a moderate rate, field extremes and a sign swing.
      write_all(32'd65536, 32'd65536, 32'd65536, 32'd1000, 32'd32767, 32'd16777215);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sd0);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sd100);
      send_sample(16'sd100);
      drain();

      // An empty window never integrates and gives zero drive.
      write_all(32'd65536, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd0);
      send_sample(16'sd50);
      send_sample(-16'sd50);
      send_sample(16'sh7FFF);
      drain();

      // Extreme gains at the top rate saturate the derivative product.
      write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65535, 32'd32767,
                32'd16777215);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      drain();
      write_reg(pidaw_pkg::REG_RATE, 32'd0);
      send_sample(16'sd5);
      drain();

      // Random configurations; one phase runs without any idling.
      phase = 0;
      while (samples_sent < NUM_ITEMS - 60) begin
         idling = (phase != 3);
         write_all(pick_gain(), pick_gain(), pick_gain(), pick_rate(),
                   ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(32767),
                   ($urandom_range(3) == 0) ? 32'd16777215 : $urandom_range(16777215));
         repeat ($urandom_range(60, 140)) send_sample(pick_sample());
         drain();
         phase++;
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pidaw_pkg.sv
hw/rtl/pidaw_ctrl.sv
hw/rtl/pidaw_dp.sv
hw/rtl/pid_conditional_antiwindup.sv
tb/sv/tb.sv
